// ----- rtl/core/voxel_face_culling_mesher_top_macros.svh -----
// Assertion macros shared by the mesher checker.
`ifndef VOXEL_FACE_CULLING_MESHER_TOP_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mesher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VFCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mesher assertion failed");

`endif

// ----- rtl/core/vfcm_pkg.sv -----
// Types, constants and face tables for the voxel face culling mesher.
`default_nettype none
package vfcm_pkg;

  localparam int unsigned CHUNK_EDGE_DEF = 32;
  localparam int unsigned NUM_FACES      = 6;
  localparam int unsigned FACE_VERTS     = 6;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_MESH  = 1'b1
  } kind_e;

  typedef struct packed {
    logic       kind;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] pos_z;
    logic [6:0] write_material;
  } in_t;

  typedef struct packed {
    logic       present;
    logic [5:0] vert_x;
    logic [5:0] vert_y;
    logic [5:0] vert_z;
    logic [6:0] vertex_material;
    logic [2:0] normal_code;
    logic [1:0] uv_corner;
    logic       last;
  } out_t;

  // Corner offset of each vertex: bit 0 is dx, bit 1 dy, bit 2 dz.
  localparam logic [2:0] CORNER_TAB [NUM_FACES][FACE_VERTS] = '{
    '{3'd5, 3'd1, 3'd3, 3'd5, 3'd3, 3'd7},
    '{3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd2},
    '{3'd6, 3'd7, 3'd3, 3'd6, 3'd3, 3'd2},
    '{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4},
    '{3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6},
    '{3'd1, 3'd0, 3'd2, 3'd1, 3'd2, 3'd3}
  };

  // Two triangles per face: LL, LR, UR, LL, UR, UL.
  localparam logic [1:0] UV_TAB [FACE_VERTS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

endpackage
`default_nettype wire

// ----- rtl/core/voxel_face_culling_mesher_top.sv -----
// Top level of the voxel face culling mesher: chunk memory and face sequencer.
// A store request is answered by one empty result in the next cycle.
// A mesh request reads the centre and then its six neighbours through one registered port
// (only the centre if it is air), then emits up to 36 vertices, one per cycle unless stalled.
// A mesh request keeps the input stalled until its last result has been registered.
// Reset clears the sequencer, output register and air code; the chunk memory is not cleared.
`default_nettype none
module voxel_face_culling_mesher_top
  import vfcm_pkg::*;
#(
  parameter int unsigned CHUNK_EDGE = CHUNK_EDGE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_t        in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_t            out_o
);

  localparam int unsigned DEPTH = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [5:0]  EDGE6 = 6'(CHUNK_EDGE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  function automatic logic [AW-1:0] lin_addr(input logic [5:0] x, input logic [5:0] y,
                                             input logic [5:0] z);
    logic [31:0] lin;
    lin = 32'(z) * 32'(CHUNK_EDGE * CHUNK_EDGE) + 32'(y) * 32'(CHUNK_EDGE) + 32'(x);
    return lin[AW-1:0];
  endfunction

  function automatic logic [2:0] lowest_face(input logic [5:0] m);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

  logic [6:0] mem [DEPTH];
  logic [6:0] rdata_q;

  state_e     state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [4:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [6:0] mat_q, mat_d;
  logic [5:0] mask_q, mask_d;
  logic       oob_q, oob_d;
  logic [2:0] face_q, face_d;
  logic [2:0] vert_q, vert_d;
  logic [6:0] air_q, air_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;

  logic          out_free;
  logic          in_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [5:0]    nx, ny, nz;
  logic [2:0]    issue_face;
  logic          air_now;
  logic [5:0]    mask_full;
  logic [5:0]    above;
  logic [2:0]    corner;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wr_en   = in_acc && (in_i.kind == KIND_STORE) && (6'(in_i.pos_x) < EDGE6)
                   && (6'(in_i.pos_y) < EDGE6) && (6'(in_i.pos_z) < EDGE6);
  assign wr_addr = lin_addr(6'(in_i.pos_x), 6'(in_i.pos_y), 6'(in_i.pos_z));

  // Step 0 looks at the centre voxel, steps 1 to 6 at the neighbour of face step-1.
  always_comb begin
    issue_face = step_q - 3'd1;
    nx = 6'(px_q);
    ny = 6'(py_q);
    nz = 6'(pz_q);
    if (step_q != 3'd0) begin
      case (issue_face)
        3'd0:    nx = nx + 6'd1;
        3'd1:    nx = nx - 6'd1;
        3'd2:    ny = ny + 6'd1;
        3'd3:    ny = ny - 6'd1;
        3'd4:    nz = nz + 6'd1;
        default: nz = nz - 6'd1;
      endcase
    end
    rd_addr = lin_addr(nx, ny, nz);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_i.write_material;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    mat_d       = mat_q;
    mask_d      = mask_q;
    oob_d       = (nx >= EDGE6) || (ny >= EDGE6) || (nz >= EDGE6);
    face_d      = face_q;
    vert_d      = vert_q;
    air_d       = cfg_we_i ? cfg_wdata_i : air_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    air_now   = oob_q || (rdata_q == air_q);
    mask_full = mask_q;
    if (step_q == 3'd7) mask_full[5] = air_now;
    above  = 6'b111110 << face_q;
    corner = CORNER_TAB[face_q][vert_q];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.kind == KIND_STORE) begin
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.last  = 1'b1;
          end else begin
            px_d    = in_i.pos_x;
            py_d    = in_i.pos_y;
            pz_d    = in_i.pos_z;
            step_d  = 3'd0;
            mask_d  = '0;
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd1) begin
          mat_d = rdata_q;
          if (air_now) state_d = ST_EMPTY;
        end else if (step_q >= 3'd2 && step_q <= 3'd6) begin
          mask_d[step_q - 3'd2] = air_now;
        end else if (step_q == 3'd7) begin
          mask_d = mask_full;
          face_d = lowest_face(mask_full);
          vert_d = 3'd0;
          state_d = (mask_full == '0) ? ST_EMPTY : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.present         = 1'b1;
          out_d.vert_x          = 6'(px_q) + 6'(corner[0]);
          out_d.vert_y          = 6'(py_q) + 6'(corner[1]);
          out_d.vert_z          = 6'(pz_q) + 6'(corner[2]);
          out_d.vertex_material = mat_q;
          out_d.normal_code     = face_q;
          out_d.uv_corner       = UV_TAB[vert_q];
          out_d.last            = (vert_q == 3'd5) && ((mask_q & above) == '0);
          if (vert_q == 3'd5) begin
            vert_d = 3'd0;
            face_d = lowest_face(mask_q & above);
            if ((mask_q & above) == '0) state_d = ST_IDLE;
          end else begin
            vert_d = vert_q + 3'd1;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      mat_q       <= '0;
      mask_q      <= '0;
      oob_q       <= 1'b0;
      face_q      <= '0;
      vert_q      <= '0;
      air_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      px_q        <= px_d;
      py_q        <= py_d;
      pz_q        <= pz_d;
      mat_q       <= mat_d;
      mask_q      <= mask_d;
      oob_q       <= oob_d;
      face_q      <= face_d;
      vert_q      <= vert_d;
      air_q       <= air_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/vfcm_checker.sv -----
// Port-level checker for the voxel face culling mesher, bound to the top level.
`default_nettype none
`include "voxel_face_culling_mesher_top_macros.svh"
module vfcm_checker
  import vfcm_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire in_t        in_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire out_t       out_o
);

  // A stalled result must hold still.
  `VFCM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o))

  // An empty result always closes its request.
  `VFCM_ASSERT_NOW(a_empty_last, out_valid_o && !out_o.present, out_o.last)

  // A vertex carries one of the six face normals.
  `VFCM_ASSERT_NOW(a_normal_range, out_valid_o && out_o.present, out_o.normal_code <= 3'd5)

  // A store request is answered by an empty last result in the very next cycle.
  `VFCM_ASSERT_NEXT(a_store_reply, in_valid_i && !in_stall_o && (in_i.kind == KIND_STORE),
                    out_valid_o && out_o.last && !out_o.present)

endmodule

bind voxel_face_culling_mesher_top vfcm_checker u_vfcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
`default_nettype wire

// ----- sim/voxel_face_culling_mesher_top_test.sv -----
// Self-checking testbench for the voxel face culling mesher top level.
module voxel_face_culling_mesher_top_test
  import vfcm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EDGE   = CHUNK_EDGE_DEF;
  localparam int unsigned VOXELS = EDGE * EDGE * EDGE;

  // Corner offsets of each face vertex: bit 0 is dx, bit 1 dy, bit 2 dz.
  localparam logic [2:0] FACE_CORNERS [6][6] = '{
    '{3'd5, 3'd1, 3'd3, 3'd5, 3'd3, 3'd7},
    '{3'd0, 3'd4, 3'd6, 3'd0, 3'd6, 3'd2},
    '{3'd6, 3'd7, 3'd3, 3'd6, 3'd3, 3'd2},
    '{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4},
    '{3'd4, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6},
    '{3'd1, 3'd0, 3'd2, 3'd1, 3'd2, 3'd3}
  };
  localparam logic [1:0] TRI_UV [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
  localparam int NBR_DX [6] = '{1, -1, 0, 0, 0, 0};
  localparam int NBR_DY [6] = '{0, 0, 1, -1, 0, 0};
  localparam int NBR_DZ [6] = '{0, 0, 0, 0, 1, -1};
  localparam out_t EMPTY_RESULT = '{last: 1'b1, default: '0};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [6:0] cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  in_t        in_req      = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  out_t       out_vertex;

  logic [6:0]  chunk_mem     [VOXELS];
  bit          chunk_written [VOXELS];
  logic [6:0]  air_code;
  out_t        expected_vertices [$];
  logic [14:0] ready_spots [$];
  int unsigned requests_sent;
  int unsigned mismatches;
  bit          sender_idles;
  bit          receiver_stalls;

  voxel_face_culling_mesher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_vertex)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit in_chunk(input int x, input int y, input int z);
    return x >= 0 && x < EDGE && y >= 0 && y < EDGE && z >= 0 && z < EDGE;
  endfunction

  function automatic int voxel_addr(input int x, input int y, input int z);
    return EDGE * (EDGE * z + y) + x;
  endfunction

  function automatic bit voxel_is_air(input int x, input int y, input int z);
    if (!in_chunk(x, y, z)) begin
      return 1'b1;
    end
    return chunk_mem[voxel_addr(x, y, z)] == air_code;
  endfunction

  // The block can read the centre and all six neighbours, so each one inside the chunk must hold a material.
  function automatic bit mesh_ready(input int x, input int y, input int z);
    if (!chunk_written[voxel_addr(x, y, z)]) begin
      return 1'b0;
    end
    for (int f = 0; f < 6; f++) begin
      if (in_chunk(x + NBR_DX[f], y + NBR_DY[f], z + NBR_DZ[f]) &&
          !chunk_written[voxel_addr(x + NBR_DX[f], y + NBR_DY[f], z + NBR_DZ[f])]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_vertices(input in_t req);
    int   x;
    int   y;
    int   z;
    int   count;
    logic [2:0] c;
    out_t v;
    x = req.pos_x;
    y = req.pos_y;
    z = req.pos_z;
    count = 0;
    if (req.kind == KIND_STORE) begin
      chunk_mem[voxel_addr(x, y, z)] = req.write_material;
      chunk_written[voxel_addr(x, y, z)] = 1'b1;
    end else if (!voxel_is_air(x, y, z)) begin
      for (int f = 0; f < 6; f++) begin
        if (voxel_is_air(x + NBR_DX[f], y + NBR_DY[f], z + NBR_DZ[f])) begin
          for (int k = 0; k < 6; k++) begin
            c = FACE_CORNERS[f][k];
            v = '0;
            v.present         = 1'b1;
            v.vert_x          = 6'(x + c[0]);
            v.vert_y          = 6'(y + c[1]);
            v.vert_z          = 6'(z + c[2]);
            v.vertex_material = chunk_mem[voxel_addr(x, y, z)];
            v.normal_code     = 3'(f);
            v.uv_corner       = TRI_UV[k];
            expected_vertices.push_back(v);
            count++;
          end
        end
      end
    end
    if (count == 0) begin
      expected_vertices.push_back(EMPTY_RESULT);
    end else begin
      v = expected_vertices.pop_back();
      v.last = 1'b1;
      expected_vertices.push_back(v);
    end
  endtask

  // This task lowers valid only ahead of a gap, so back-to-back requests keep it high.
  task automatic send_request(input kind_e kind, input int x, input int y, input int z,
                              input logic [6:0] material);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid              <= 1'b1;
    in_req.kind           <= kind;
    in_req.pos_x          <= 5'(x);
    in_req.pos_y          <= 5'(y);
    in_req.pos_z          <= 5'(z);
    in_req.write_material <= material;
    do @(posedge clk_i); while (in_stall);
    predict_vertices(in_req);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (expected_vertices.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_air_code(input logic [6:0] code);
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk_i);
    air_code = code;
    cfg_we   <= 1'b0;
  endtask

  function automatic int pick_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return EDGE - 1;
    if (r < 35) return 1;
    if (r < 40) return EDGE - 2;
    return $urandom_range(0, EDGE - 1);
  endfunction

  function automatic logic [6:0] pick_material();
    if ($urandom_range(0, 9) < 4) begin
      return air_code;
    end
    return 7'($urandom_range(0, 127));
  endfunction

  // Store the centre and its neighbours (fresh ones always, known ones sometimes), then mesh.
  task automatic build_and_mesh(input int x, input int y, input int z);
    int nx;
    int ny;
    int nz;
    for (int f = -1; f < 6; f++) begin
      nx = (f < 0) ? x : x + NBR_DX[f];
      ny = (f < 0) ? y : y + NBR_DY[f];
      nz = (f < 0) ? z : z + NBR_DZ[f];
      if (in_chunk(nx, ny, nz) &&
          (!chunk_written[voxel_addr(nx, ny, nz)] || $urandom_range(0, 1) == 1)) begin
        send_request(KIND_STORE, nx, ny, nz, pick_material());
      end
    end
    if (mesh_ready(x, y, z)) begin
      send_request(KIND_MESH, x, y, z, 7'($urandom_range(0, 127)));
      ready_spots.push_back({5'(x), 5'(y), 5'(z)});
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t exp_v;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        exp_v = expected_vertices.pop_front();
        check_field("present", exp_v.present, out_vertex.present);
        check_field("vert_x", exp_v.vert_x, out_vertex.vert_x);
        check_field("vert_y", exp_v.vert_y, out_vertex.vert_y);
        check_field("vert_z", exp_v.vert_z, out_vertex.vert_z);
        check_field("vertex_material", exp_v.vertex_material, out_vertex.vertex_material);
        check_field("normal_code", exp_v.normal_code, out_vertex.normal_code);
        check_field("uv_corner", exp_v.uv_corner, out_vertex.uv_corner);
        check_field("last", exp_v.last, out_vertex.last);
      end
    end
  end

  // Result side back-pressure: a random stall ahead of each accepted result.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = receiver_stalls ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Exposed faces at the low and high corners of the chunk, an air voxel,
  // and a fully enclosed solid voxel.
  task automatic test_boundary_faces();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    set_air_code(7'd0);
    send_request(KIND_STORE, 0, 0, 0, 7'd127);
    send_request(KIND_STORE, 1, 0, 0, 7'd0);
    send_request(KIND_STORE, 0, 1, 0, 7'd0);
    send_request(KIND_STORE, 0, 0, 1, 7'd0);
    send_request(KIND_MESH, 0, 0, 0, 7'd0);
    send_request(KIND_STORE, EDGE - 1, EDGE - 1, EDGE - 1, 7'h2a);
    send_request(KIND_STORE, EDGE - 2, EDGE - 1, EDGE - 1, 7'd127);
    send_request(KIND_STORE, EDGE - 1, EDGE - 2, EDGE - 1, 7'h05);
    send_request(KIND_STORE, EDGE - 1, EDGE - 1, EDGE - 2, 7'h40);
    send_request(KIND_MESH, EDGE - 1, EDGE - 1, EDGE - 1, 7'd127);
    for (int f = 0; f < 6; f++) begin
      send_request(KIND_STORE, 5 + NBR_DX[f], 5 + NBR_DY[f], 5 + NBR_DZ[f], 7'h11);
    end
    send_request(KIND_STORE, 5, 5, 5, 7'd0);
    send_request(KIND_MESH, 5, 5, 5, 7'h7f);
    send_request(KIND_STORE, 5, 5, 5, 7'h55);
    send_request(KIND_MESH, 5, 5, 5, 7'h00);
    ready_spots.push_back({5'd0, 5'd0, 5'd0});
    ready_spots.push_back({5'(EDGE - 1), 5'(EDGE - 1), 5'(EDGE - 1)});
    ready_spots.push_back({5'd5, 5'd5, 5'd5});
  endtask

  task automatic test_random_chunk(input logic [6:0] air, input int unsigned budget,
                                   input bit idles);
    int unsigned start;
    int unsigned pick;
    logic [14:0] spot;
    set_air_code(air);
    sender_idles    = idles;
    receiver_stalls = idles;
    start = requests_sent;
    while (requests_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || ready_spots.size() == 0) begin
        build_and_mesh(pick_coord(), pick_coord(), pick_coord());
      end else if (pick < 82) begin
        spot = ready_spots[$urandom_range(0, ready_spots.size() - 1)];
        send_request(KIND_MESH, spot[14:10], spot[9:5], spot[4:0], 7'($urandom_range(0, 127)));
      end else begin
        send_request(KIND_STORE, $urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                     $urandom_range(0, EDGE - 1), pick_material());
      end
      if ($urandom_range(0, 29) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  initial begin
    air_code      = 7'd0;
    requests_sent = 0;
    mismatches    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundary_faces();
    test_random_chunk(7'd127, 65, 1'b1);
    test_random_chunk(7'($urandom_range(1, 126)), 65, 1'b0);
    test_random_chunk(7'd0, 65, 1'b1);
    wait_for_drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
